[hw/rtl/mstt_pkg.sv]
// shared types and constants of the timer slot table
// no dependencies; used by the controller, datapath, top level and the bench
`timescale 1ns / 1ps

package mstt_pkg;

    // result kinds
    localparam logic [1:0] EV_ADDED    = 2'd0;
    localparam logic [1:0] EV_REJECTED = 2'd1;
    localparam logic [1:0] EV_FIRED    = 2'd2;

    // reported firings per tick are capped
    localparam int         CNT_W       = 5;
    localparam logic [4:0] MAX_REPORTS = 5'd16;

    typedef struct packed {
        logic [15:0]        period;
        logic [15:0]        remaining;
        logic signed [15:0] repeats;
        logic [7:0]         callback;
        logic [31:0]        context_word;
    } mstt_slot_t;

    typedef struct packed {
        logic take;          // input channel ready
        logic idx_inc;       // advance the slot index
        logic mem_rd;        // read the slot record at the index
        logic add_wr;        // claim the slot at the index for the held add
        logic slot_step;     // write back the ticked slot record
        logic emit_added;
        logic emit_rejected;
        logic emit_last;     // flush the held firing as the final beat
    } mstt_cmd_t;

    typedef struct packed {
        logic accepted;
        logic is_tick;
        logic per_zero;
        logic cur_active;
        logic idx_last;
        logic out_free;
        logic pend_valid;
        logic upd_stall;
    } mstt_sts_t;

endpackage

[hw/rtl/mstt_in_if.sv]
// input item channel of the timer slot table
// depends on nothing; valid/ready handshake with the add/tick payload
`timescale 1ns / 1ps

interface mstt_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] repeat_count;
    logic [15:0]        period_ticks;
    logic [7:0]         callback_id;
    logic [31:0]        context_word;

    modport source (
        output valid, func, repeat_count, period_ticks, callback_id, context_word,
        input  ready
    );
    modport sink (
        input  valid, func, repeat_count, period_ticks, callback_id, context_word,
        output ready
    );
endinterface

[hw/rtl/mstt_out_if.sv]
// result channel of the timer slot table
// depends on nothing; valid/ready handshake with the event payload
`timescale 1ns / 1ps

interface mstt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [3:0]  slot_index;
    logic [7:0]  fired_callback;
    logic [31:0] fired_context;
    logic        last;

    modport source (
        output valid, event_kind, slot_index, fired_callback, fired_context, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, slot_index, fired_callback, fired_context, last,
        output ready
    );
endinterface

[hw/rtl/mstt_ctrl.sv]
// sequencer of the timer slot table: add search and tick scan
// depends on mstt_pkg; drives mstt_dp through command and status structs
`timescale 1ns / 1ps

module mstt_ctrl
    import mstt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mstt_sts_t sts,
    output mstt_cmd_t cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        ADD_SCAN,
        ADD_OK,
        ADD_FAIL,
        TICK_RD,
        TICK_UPD,
        TICK_END
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.accepted)
                begin
                    state_next = DECODE;
                end
            end
            DECODE:
            begin
                if (sts.is_tick)
                begin
                    state_next = TICK_RD;
                end
                else if (sts.per_zero)
                begin
                    state_next = ADD_FAIL;
                end
                else
                begin
                    state_next = ADD_SCAN;
                end
            end
            ADD_SCAN:
            begin
                if (!sts.cur_active)
                begin
                    cmd.add_wr = 1'b1;
                    state_next = ADD_OK;
                end
                else if (sts.idx_last)
                begin
                    state_next = ADD_FAIL;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ADD_OK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_added = 1'b1;
                    state_next     = IDLE;
                end
            end
            ADD_FAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_rejected = 1'b1;
                    state_next        = IDLE;
                end
            end
            TICK_RD:
            begin
                if (sts.cur_active)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = TICK_UPD;
                end
                else if (sts.idx_last)
                begin
                    state_next = TICK_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            TICK_UPD:
            begin
                if (!sts.upd_stall)
                begin
                    cmd.slot_step = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = TICK_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = TICK_RD;
                    end
                end
            end
            TICK_END:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a tick that ends with nothing held goes straight back to idle
    a_quiet_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TICK_END && !sts.pend_valid) |=> state_reg == IDLE)
        else $error("tick end did not return to idle");

endmodule

[hw/rtl/mstt_dp.sv]
// datapath of the timer slot table: slot memory, active bits, index,
// held firing and output register; depends on mstt_pkg and the channel interfaces
`timescale 1ns / 1ps

module mstt_dp
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    mstt_in_if.sink   item,
    mstt_out_if.source result,
    input  mstt_cmd_t cmd,
    output mstt_sts_t sts
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

    // slot records; entries are read only after an add wrote them
    mstt_slot_t mem [NUM_SLOTS];
    mstt_slot_t rd_reg;

    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    // held add item
    logic               is_tick_reg;
    logic signed [15:0] reps_reg;
    logic [15:0]        per_reg;
    logic [7:0]         cb_reg;
    logic [31:0]        ctx_reg;

    // held firing, reported once the next one or the end of the scan is known
    logic             pend_valid_reg, pend_valid_next;
    logic [3:0]       pend_slot_reg;
    logic [7:0]       pend_cb_reg;
    logic [31:0]      pend_ctx_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [3:0]  out_slot_reg;
    logic [7:0]  out_cb_reg;
    logic [31:0] out_ctx_reg;
    logic        out_last_reg;

    logic               accepted;
    logic               out_free;
    logic [15:0]        rem_dec;
    logic               fire;
    logic               reportable;
    logic               report;
    logic signed [15:0] reps_new;
    logic               keep;
    mstt_slot_t         upd_rec;
    mstt_slot_t         add_rec;
    logic               emit_pend;
    logic               out_load;

    assign accepted = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;

    // tick update of the slot record held in the read register
    assign rem_dec    = rd_reg.remaining - 16'd1;
    assign fire       = (rem_dec == 16'd0);
    assign reportable = (cnt_reg < MAX_REPORTS);
    assign report     = fire && reportable;
    assign reps_new   = (rd_reg.repeats > 16'sd0) ? rd_reg.repeats - 16'sd1 : rd_reg.repeats;
    assign keep       = (reps_new != 16'sd0);

    always_comb
    begin
        upd_rec = rd_reg;
        if (fire)
        begin
            upd_rec.repeats   = reps_new;
            upd_rec.remaining = rd_reg.period;
        end
        else
        begin
            upd_rec.remaining = rem_dec;
        end
    end

    assign add_rec = '{period: per_reg, remaining: per_reg, repeats: reps_reg,
                       callback: cb_reg, context_word: ctx_reg};

    assign emit_pend = cmd.slot_step && report && pend_valid_reg;
    assign out_load  = cmd.emit_added || cmd.emit_rejected || cmd.emit_last || emit_pend;

    always_comb
    begin
        active_next = active_reg;
        if (cmd.add_wr)
        begin
            active_next[idx_reg] = 1'b1;
        end
        else if (cmd.slot_step && fire && !keep)
        begin
            active_next[idx_reg] = 1'b0;
        end

        idx_next = idx_reg;
        if (accepted)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end

        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        if (accepted || cmd.emit_last)
        begin
            pend_valid_next = 1'b0;
            cnt_next        = '0;
        end
        else if (cmd.slot_step && report)
        begin
            pend_valid_next = 1'b1;
            cnt_next        = cnt_reg + 1'b1;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
        begin
            mem[idx_reg] <= add_rec;
        end
        else if (cmd.slot_step)
        begin
            mem[idx_reg] <= upd_rec;
        end
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            is_tick_reg <= item.func;
            reps_reg    <= item.repeat_count;
            per_reg     <= item.period_ticks;
            cb_reg      <= item.callback_id;
            ctx_reg     <= item.context_word;
        end
        if (cmd.slot_step && report)
        begin
            pend_slot_reg <= 4'(idx_reg);
            pend_cb_reg   <= rd_reg.callback;
            pend_ctx_reg  <= rd_reg.context_word;
        end
        if (out_load)
        begin
            if (cmd.emit_added || cmd.emit_rejected)
            begin
                out_kind_reg <= cmd.emit_added ? EV_ADDED : EV_REJECTED;
                out_slot_reg <= cmd.emit_added ? 4'(idx_reg) : 4'd0;
                out_cb_reg   <= 8'd0;
                out_ctx_reg  <= 32'd0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_kind_reg <= EV_FIRED;
                out_slot_reg <= pend_slot_reg;
                out_cb_reg   <= pend_cb_reg;
                out_ctx_reg  <= pend_ctx_reg;
                out_last_reg <= cmd.emit_last;
            end
        end
    end

    assign item.ready            = cmd.take;
    assign result.valid          = out_valid_reg;
    assign result.event_kind     = out_kind_reg;
    assign result.slot_index     = out_slot_reg;
    assign result.fired_callback = out_cb_reg;
    assign result.fired_context  = out_ctx_reg;
    assign result.last           = out_last_reg;

    assign sts.accepted   = accepted;
    assign sts.is_tick    = is_tick_reg;
    assign sts.per_zero   = (per_reg == 16'd0);
    assign sts.cur_active = active_reg[idx_reg];
    assign sts.idx_last   = (idx_reg == IDX_LAST);
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.upd_stall  = report && pend_valid_reg && !out_free;

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_REPORTS)
        else $error("firing report count above cap");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten before it was taken");

    a_add_claims: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_wr |=> active_reg[$past(idx_reg)])
        else $error("added slot not marked active");

endmodule

[hw/rtl/multi_slot_periodic_timer_table_core.sv]
// top level of the timer slot table: controller plus datapath
// depends on mstt_pkg, mstt_in_if, mstt_out_if, mstt_ctrl and mstt_dp
`timescale 1ns / 1ps

// Table of NUM_SLOTS periodic timer slots, one item in flight at a time. An add
// with a nonzero period searches the slots from 0 upward, one per cycle, and
// claims the first free one; it is rejected when the period is zero or the table
// is full. A tick walks every slot through one record memory: a free slot is
// skipped and an active one is read, then updated and written back; the update
// and the end of the scan wait while the sink holds the output register. Each
// reported firing is held until the next one or the end of the scan, which is
// how the final beat gets its last flag. The output register lets the result
// wait while the next item is taken.

module multi_slot_periodic_timer_table_core
    import mstt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mstt_in_if.sink    item,
    mstt_out_if.source result
);

    mstt_cmd_t cmd;
    mstt_sts_t sts;

    mstt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mstt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

[tb/timer_event_checker.sv]
// checker for the timer slot table: predicts events from accepted item beats,
// compares them with result beats. depends on mstt_pkg, mstt_in_if, mstt_out_if
`timescale 1ns / 1ps

package mstt_tb_pkg;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [7:0]  callback;
        logic [31:0] context_word;
        logic        last;
    } timer_event_t;

endpackage

module timer_event_checker
    import mstt_pkg::*;
    import mstt_tb_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    mstt_in_if   item,
    mstt_out_if  result,
    output int   mismatches,
    output int   pending
);

    bit                 slot_armed    [NUM_SLOTS];
    logic [15:0]        slot_period   [NUM_SLOTS];
    logic [15:0]        slot_left     [NUM_SLOTS];
    logic signed [15:0] slot_repeats  [NUM_SLOTS];
    logic [7:0]         slot_callback [NUM_SLOTS];
    logic [31:0]        slot_word     [NUM_SLOTS];
    timer_event_t       due_events[$];

    function automatic int field_differs(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // lowest free slot takes the add; zero period or no free slot is rejected
    task automatic predict_add(logic signed [15:0] reps, logic [15:0] per, logic [7:0] cb,
                               logic [31:0] word);
        timer_event_t ev;
        ev      = '0;
        ev.kind = EV_REJECTED;
        ev.last = 1'b1;
        if (per != 16'd0) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (!slot_armed[s] && ev.kind == EV_REJECTED) begin
                    slot_armed[s]    = 1'b1;
                    slot_period[s]   = per;
                    slot_left[s]     = per;
                    slot_repeats[s]  = reps;
                    slot_callback[s] = cb;
                    slot_word[s]     = word;
                    ev.kind          = EV_ADDED;
                    ev.slot          = 4'(s);
                end
            end
        end
        due_events.push_back(ev);
    endtask

    // a firing is held back until the next one so the final one can carry last
    task automatic predict_tick();
        timer_event_t held;
        bit           have_held;
        int           reported;
        held      = '0;
        have_held = 1'b0;
        reported  = 0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_armed[s]) begin
                slot_left[s] = slot_left[s] - 16'd1;
                if (slot_left[s] == 16'd0) begin
                    if (reported < MAX_REPORTS) begin
                        if (have_held)
                            due_events.push_back(held);
                        held              = '0;
                        held.kind         = EV_FIRED;
                        held.slot         = 4'(s);
                        held.callback     = slot_callback[s];
                        held.context_word = slot_word[s];
                        have_held         = 1'b1;
                        reported++;
                    end
                    if (slot_repeats[s] > 16'sd0)
                        slot_repeats[s] = slot_repeats[s] - 16'sd1;
                    if (slot_repeats[s] != 16'sd0)
                        slot_left[s] = slot_period[s];
                    else
                        slot_armed[s] = 1'b0;
                end
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            due_events.push_back(held);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        timer_event_t want;
        if (!rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++)
                slot_armed[s] = 1'b0;
            due_events.delete();
            pending = 0;
        end
        else begin
            if (result.valid === 1'b1 && result.ready === 1'b1) begin
                if (due_events.size() == 0) begin
                    $error("unexpected result beat: event_kind %0d slot_index %0d",
                           result.event_kind, result.slot_index);
                    mismatches++;
                end
                else begin
                    want = due_events.pop_front();
                    mismatches += field_differs("event_kind", want.kind, result.event_kind);
                    mismatches += field_differs("slot_index", want.slot, result.slot_index);
                    mismatches += field_differs("fired_callback", want.callback,
                                                result.fired_callback);
                    mismatches += field_differs("fired_context", want.context_word,
                                                result.fired_context);
                    mismatches += field_differs("last", want.last, result.last);
                end
            end
            if (item.valid === 1'b1 && item.ready === 1'b1) begin
                if (item.func == FUNC_TICK)
                    predict_tick();
                else
                    predict_add(item.repeat_count, item.period_ticks, item.callback_id,
                                item.context_word);
            end
            pending = due_events.size();
        end
    end

endmodule

[tb/testbench.sv]
// top of the timer slot table bench: clock, reset, item and result drivers
// depends on mstt_pkg, mstt_in_if, mstt_out_if, the core and timer_event_checker
`timescale 1ns / 1ps

module testbench;
    import mstt_pkg::*;
    import mstt_tb_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 335;
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 20;
    localparam int HOLD_START   = 1500;
    localparam int HOLD_LEN     = 300;
    localparam int CALM_START   = 3000;
    localparam int CALM_LEN     = 1500;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    bit   sender_calm;

    mstt_in_if  item_ch ();
    mstt_out_if result_ch ();

    multi_slot_periodic_timer_table_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    timer_event_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("multi_slot_periodic_timer_table_core verification failed");
        $finish;
    end

    // result side: random stalls, one long hold-off, one stretch always ready
    initial begin
        int cycle;
        cycle           = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            cycle++;
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_LEN)
                result_ch.ready <= 1'b0;
            else if (cycle >= CALM_START && cycle < CALM_START + CALM_LEN)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 6);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic offer_beat(logic fn, logic signed [15:0] reps, logic [15:0] per,
                              logic [7:0] cb, logic [31:0] word);
        while (!sender_calm && $urandom_range(99) < 6) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.func         <= fn;
        item_ch.repeat_count <= reps;
        item_ch.period_ticks <= per;
        item_ch.callback_id  <= cb;
        item_ch.context_word <= word;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        int                 pick;
        logic [15:0]        per;
        logic signed [15:0] reps;
        rst_n                = 1'b0;
        sender_calm          = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.func         = FUNC_ADD;
        item_ch.repeat_count = '0;
        item_ch.period_ticks = '0;
        item_ch.callback_id  = '0;
        item_ch.context_word = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // quiet tick on an empty table, then a zero-period reject
        offer_beat(FUNC_TICK, 16'sh7fff, 16'hffff, 8'hff, 32'hffff_ffff);
        offer_beat(FUNC_ADD, 16'sh7fff, 16'd0, 8'hff, 32'hffff_ffff);
        // one-shot, counted, forever and very long timers
        offer_beat(FUNC_ADD, 16'sd0, 16'd1, 8'hff, 32'hffff_ffff);
        offer_beat(FUNC_ADD, 16'sd2, 16'd2, 8'h00, 32'h0000_0000);
        offer_beat(FUNC_ADD, -16'sd32768, 16'd3, 8'h5a, 32'hdead_beef);
        offer_beat(FUNC_ADD, 16'sh7fff, 16'hffff, 8'ha5, 32'h1234_5678);
        repeat (4)
            offer_beat(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
        // fill the table, overflow it, then expire the fill in one tick
        for (int k = 0; k < NUM_SLOTS - 2; k++)
            offer_beat(FUNC_ADD, 16'sd1, 16'd1, 8'(k + 1), $urandom);
        offer_beat(FUNC_ADD, 16'sd1, 16'd1, 8'h77, 32'h0bad_cafe);
        offer_beat(FUNC_TICK, 16'sd0, 16'd0, 8'd0, 32'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_calm = (n >= 150 && n < 260);
            if ($urandom_range(99) < 45) begin
                offer_beat(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
            end
            else begin
                pick = $urandom_range(99);
                if (pick < 5)
                    per = 16'd0;
                else if (pick < 6)
                    per = 16'($urandom);
                else
                    per = 16'($urandom_range(8, 1));
                // wide repeat counts are rare since they tie up a slot for long or for good
                if ($urandom_range(99) < 2)
                    reps = 16'($urandom);
                else
                    reps = 16'($urandom_range(4, 0));
                offer_beat(FUNC_ADD, reps, per, 8'($urandom), $urandom);
            end
        end
        item_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("multi_slot_periodic_timer_table_core verification clean");
        else
            $display("multi_slot_periodic_timer_table_core verification failed");
        $finish;
    end

endmodule
